/* hdl/slvs_pkg.sv */
`timescale 1ns / 1ps

package slvs_pkg;

	// Table geometry.
	localparam int SLOT_COUNT  = 16;
	localparam int STAMP_WIDTH = 48;
	localparam int SLOT_W      = 8;
	localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam logic [STAMP_WIDTH-1:0] STAMP_MAX  = {STAMP_WIDTH{1'b1}};
	localparam logic [STAMP_WIDTH-1:0] STAMP_ZERO = '0;
	localparam logic [STAMP_WIDTH-1:0] STAMP_ONE  = STAMP_WIDTH'(1);

	// Request codes.
	localparam logic [1:0] REQ_FILL       = 2'd0;
	localparam logic [1:0] REQ_HIT        = 2'd1;
	localparam logic [1:0] REQ_INVALIDATE = 2'd2;
	localparam logic [1:0] REQ_CANDIDATE  = 2'd3;

	// Status codes.
	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd1;
	localparam logic [1:0] STATUS_EMPTY_SET   = 2'd2;

	// Replacement policies.
	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [SLOT_W-1:0] slot;
		logic              last_candidate;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              victim_valid;
		logic [SLOT_W-1:0] victim_slot;
	} resp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
	} dp_cmd_t;

endpackage

/* hdl/slvs_ctrl.sv */
`timescale 1ns / 1ps

module slvs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output slvs_pkg::dp_cmd_t cmd
);

	typedef enum logic {
		ST_EMPTY,
		ST_FULL
	} state_t;

	state_t state_q;

	// A new beat is taken when the result register is empty or is drained this cycle.
	assign in_ready   = (state_q == ST_EMPTY) || out_ready;
	assign out_valid  = (state_q == ST_FULL);
	assign cmd.accept = in_valid && in_ready;

	// Occupancy of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			unique case (state_q)
				ST_EMPTY: begin
					if (in_valid) state_q <= ST_FULL;
				end
				ST_FULL: begin
					if (out_ready && !in_valid) state_q <= ST_EMPTY;
				end
				default: state_q <= ST_EMPTY;
			endcase
		end
	end

endmodule

/* hdl/slvs_datapath.sv */
`timescale 1ns / 1ps

module slvs_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  slvs_pkg::dp_cmd_t cmd,
	input  slvs_pkg::req_t    req,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	output slvs_pkg::resp_t   resp
);

	logic [slvs_pkg::STAMP_WIDTH-1:0] stamp_q [slvs_pkg::SLOT_COUNT];
	logic [slvs_pkg::STAMP_WIDTH-1:0] next_stamp_q;
	logic [slvs_pkg::STAMP_WIDTH-1:0] best_stamp_q;
	logic [slvs_pkg::SLOT_W-1:0]      best_slot_q;
	logic                             have_best_q;
	logic                             policy_q;
	slvs_pkg::resp_t                  resp_q;

	logic                             in_range;
	logic [slvs_pkg::IDX_W-1:0]       idx;
	logic [slvs_pkg::STAMP_WIDTH-1:0] cand_stamp;
	logic                             better;
	logic                             do_stamp;
	logic                             do_clear;
	logic                             is_cand;
	logic                             have_after;
	logic [slvs_pkg::SLOT_W-1:0]      slot_after;
	logic [slvs_pkg::STAMP_WIDTH-1:0] stamp_after;

	// Decode the beat and read the named slot's stamp.
	always_comb begin
		in_range   = {1'b0, req.slot} < (slvs_pkg::SLOT_W + 1)'(slvs_pkg::SLOT_COUNT);
		idx        = slvs_pkg::IDX_W'(req.slot);
		cand_stamp = stamp_q[idx];
		is_cand    = (req.req_type == slvs_pkg::REQ_CANDIDATE);
		do_stamp   = in_range && ((req.req_type == slvs_pkg::REQ_FILL) ||
			((req.req_type == slvs_pkg::REQ_HIT) && (policy_q == slvs_pkg::POLICY_LRU)));
		do_clear   = in_range && (req.req_type == slvs_pkg::REQ_INVALIDATE);
		better     = !have_best_q || (cand_stamp < best_stamp_q) ||
			((cand_stamp == best_stamp_q) && (req.slot < best_slot_q));
	end

	// Running minimum after this candidate is folded in.
	always_comb begin
		have_after  = have_best_q;
		slot_after  = best_slot_q;
		stamp_after = best_stamp_q;
		if (is_cand && in_range && better) begin
			have_after  = 1'b1;
			slot_after  = req.slot;
			stamp_after = cand_stamp;
		end
	end

	// Policy register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= slvs_pkg::POLICY_LRU;
		end else if (cfg_wr_en) begin
			policy_q <= cfg_wr_data;
		end
	end

	// Stamp table and the saturating stamp counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < slvs_pkg::SLOT_COUNT; i++) begin
				stamp_q[i] <= slvs_pkg::STAMP_ZERO;
			end
			next_stamp_q <= slvs_pkg::STAMP_ONE;
		end else if (cmd.accept) begin
			if (do_stamp) begin
				stamp_q[idx] <= next_stamp_q;
				if (next_stamp_q != slvs_pkg::STAMP_MAX) begin
					next_stamp_q <= next_stamp_q + slvs_pkg::STAMP_ONE;
				end
			end else if (do_clear) begin
				stamp_q[idx] <= slvs_pkg::STAMP_ZERO;
			end
		end
	end

	// Query state; the final candidate closes the query.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q  <= 1'b0;
			best_slot_q  <= '0;
			best_stamp_q <= slvs_pkg::STAMP_ZERO;
		end else if (cmd.accept && is_cand) begin
			if (req.last_candidate) begin
				have_best_q  <= 1'b0;
				best_slot_q  <= '0;
				best_stamp_q <= slvs_pkg::STAMP_ZERO;
			end else begin
				have_best_q  <= have_after;
				best_slot_q  <= slot_after;
				best_stamp_q <= stamp_after;
			end
		end
	end

	// Result register, loaded with every accepted beat.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (is_cand && req.last_candidate && have_after) begin
				resp_q.status       <= in_range ? slvs_pkg::STATUS_OK :
					slvs_pkg::STATUS_OUT_OF_RANGE;
				resp_q.victim_valid <= 1'b1;
				resp_q.victim_slot  <= slot_after;
			end else if (is_cand && req.last_candidate) begin
				resp_q.status       <= slvs_pkg::STATUS_EMPTY_SET;
				resp_q.victim_valid <= 1'b0;
				resp_q.victim_slot  <= '0;
			end else begin
				resp_q.status       <= in_range ? slvs_pkg::STATUS_OK :
					slvs_pkg::STATUS_OUT_OF_RANGE;
				resp_q.victim_valid <= 1'b0;
				resp_q.victim_slot  <= '0;
			end
		end
	end

	assign resp = resp_q;

endmodule

/* hdl/stamp_lru_fifo_victim_select.sv */
`timescale 1ns / 1ps

// Timestamp LRU / FIFO victim selection.
// The input channel carries request beats (fill, hit, invalidate or victim
// candidate, with a slot id and a last-candidate mark); every request beat
// yields exactly one result beat on the output channel, in order.
// Each slot keeps a stamp taken from a saturating counter. A victim query is
// a run of candidate beats; the beat marked last returns the slot with the
// smallest stamp seen, ties going to the smaller slot id.
// A result is registered at the edge that accepts its request. Throughput is
// one beat per cycle while the receiver is ready, set by the single result
// register, which is reloaded in the same cycle it is drained.
// When the receiver stalls, the result register holds its beat and in_ready
// falls, so no further request is taken until the result is taken.
// Reset clears all stamps to zero, sets the counter to one, closes any open
// query and selects LRU policy. cfg_wr_en writes the policy bit (0 LRU,
// 1 FIFO) and should be used only while the block is idle.
module stamp_lru_fifo_victim_select (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  slvs_pkg::req_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output slvs_pkg::resp_t  out_data,
	input  logic             cfg_wr_en,
	input  logic             cfg_wr_data
);

	slvs_pkg::dp_cmd_t cmd;

	// Handshake controller.
	slvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Stamp table, query state and result register.
	slvs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req         (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.resp        (out_data)
	);

endmodule
